// File: sv/assert_macros.svh
// Assertion macros used by the run averager back end (tra_back).
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TRA_ASSERT_IMPL(label, ante, cons, msg) \
  `TRA_ASSERT(label, (ante) |-> (cons), msg)

`define TRA_ASSERT_NEXT(label, ante, cons, msg) \
  `TRA_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: sv/tra_pkg.sv
// Shared constants for the tied run averager.
// No dependencies.
package tra_pkg;
  localparam int VALUE_W     = 32;
  localparam int MAX_RUN_DEF = 64;
  localparam int QDEPTH      = 2;
endpackage

// File: sv/tra_front.sv
// Front end: accumulates the open run and closes it into the run queue.
// Depends on tra_pkg.
module tra_front #(
  parameter int MAX_RUN = tra_pkg::MAX_RUN_DEF,
  localparam int SUM_W = tra_pkg::VALUE_W + $clog2(MAX_RUN),
  localparam int CNT_W = $clog2(MAX_RUN + 1),
  localparam int REC_W = SUM_W + CNT_W + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tra_pkg::VALUE_W-1:0] in_tdata,
  input  logic                        in_tuser,
  input  logic                        in_tlast,
  output logic                        push,
  output logic [REC_W-1:0]            push_data,
  input  logic                        q_full
);
  import tra_pkg::*;

  logic signed [SUM_W-1:0] sum_r, sum_nxt, sum_new;
  logic [CNT_W-1:0]        count_r, count_nxt, count_new;
  logic                    accept, cut, close;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    sum_new   = sum_r + {{(SUM_W-VALUE_W){in_tdata[VALUE_W-1]}}, in_tdata};
    count_new = count_r + CNT_W'(1);
    cut       = (count_new >= CNT_W'(MAX_RUN)) && in_tuser && !in_tlast;
    close     = !in_tuser || in_tlast || cut;
    push      = accept && close;
    push_data = {cut, count_new, sum_new};
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (accept) begin
      if (close) begin
        sum_nxt   = '0;
        count_nxt = '0;
      end else begin
        sum_nxt   = sum_new;
        count_nxt = count_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end
endmodule

// File: sv/tra_queue.sv
// Short FIFO of closed runs between front and back end.
// Depends on tra_pkg.
module tra_queue #(
  parameter int MAX_RUN = tra_pkg::MAX_RUN_DEF,
  localparam int SUM_W = tra_pkg::VALUE_W + $clog2(MAX_RUN),
  localparam int CNT_W = $clog2(MAX_RUN + 1),
  localparam int REC_W = SUM_W + CNT_W + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [REC_W-1:0] push_data,
  output logic             q_full,
  output logic             q_valid,
  output logic [REC_W-1:0] q_data,
  input  logic             pop
);
  import tra_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int FILL_W = $clog2(QDEPTH + 1);

  logic [REC_W-1:0]  mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] fill_r;

  assign q_full  = (fill_r == FILL_W'(QDEPTH));
  assign q_valid = (fill_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
      case ({push, pop})
        2'b10:   fill_r <= fill_r + FILL_W'(1);
        2'b01:   fill_r <= fill_r - FILL_W'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end
endmodule

// File: sv/tra_back.sv
// Back end: divides a closed run's sum by its count, then emits one beat per member.
// Depends on tra_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tra_back #(
  parameter int MAX_RUN = tra_pkg::MAX_RUN_DEF,
  localparam int SUM_W = tra_pkg::VALUE_W + $clog2(MAX_RUN),
  localparam int CNT_W = $clog2(MAX_RUN + 1),
  localparam int REC_W = SUM_W + CNT_W + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  logic [REC_W-1:0]            q_data,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tra_pkg::VALUE_W-1:0] out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);
  import tra_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;

  state_t             state_r;
  logic [SUM_W-1:0]   quo_r, quo_nxt, sum_mag;
  logic [CNT_W-1:0]   div_r, rem_r, rem_nxt, left_r;
  logic [CNT_W:0]     rem_sh;
  logic [STEP_W-1:0]  step_r;
  logic               neg_r, cut_r, ge;
  logic [SUM_W-1:0]   q_sum;
  logic [SUM_W-1:0]   mean_full;
  logic               out_tvalid_r, out_tlast_r, out_tuser_r;
  logic [VALUE_W-1:0] out_tdata_r;

  assign q_sum   = q_data[SUM_W-1:0];
  assign sum_mag = q_sum[SUM_W-1] ? (~q_sum + SUM_W'(1)) : q_sum;
  assign pop     = (state_r == S_IDLE) && q_valid;

  always_comb begin
    rem_sh    = {rem_r, quo_r[SUM_W-1]};
    ge        = (rem_sh >= {1'b0, div_r});
    rem_nxt   = ge ? CNT_W'(rem_sh - {1'b0, div_r}) : rem_sh[CNT_W-1:0];
    quo_nxt   = {quo_r[SUM_W-2:0], ge};
    mean_full = neg_r ? (~quo_nxt + SUM_W'(1)) : quo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            quo_r   <= sum_mag;
            neg_r   <= q_sum[SUM_W-1];
            div_r   <= q_data[SUM_W +: CNT_W];
            left_r  <= q_data[SUM_W +: CNT_W];
            cut_r   <= q_data[REC_W-1];
            rem_r   <= '0;
            step_r  <= STEP_W'(SUM_W-1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          quo_r  <= quo_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r - STEP_W'(1);
          if (step_r == '0) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= mean_full[VALUE_W-1:0];
            out_tlast_r  <= (left_r == CNT_W'(1));
            out_tuser_r  <= cut_r;
            state_r      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_tready) begin
            left_r      <= left_r - CNT_W'(1);
            out_tlast_r <= (left_r == CNT_W'(2));
            if (left_r == CNT_W'(1)) begin
              out_tvalid_r <= 1'b0;
              state_r      <= S_IDLE;
            end
          end
        end
        default: begin
          out_tvalid_r <= 1'b0;
          state_r      <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  `TRA_ASSERT_IMPL(a_no_beat_off_emit, state_r != S_EMIT, !out_tvalid, "beat outside emit")
  `TRA_ASSERT_IMPL(a_left_nonzero, out_tvalid, left_r != '0, "emit with no members left")
  `TRA_ASSERT_NEXT(a_idle_after_last, out_tvalid && out_tready && out_tlast, !out_tvalid,
                   "beat after run's last")
endmodule

// File: sv/tied_run_averager_core.sv
// Tied run averager: emits each run's mean once per member; runs are cut at MAX_RUN members.
// Throughput: front takes one beat per cycle while the run queue is not full; back
// handles one run at a time, popping it only when idle, dividing its sum with a bit-serial
// divider, then emitting one beat per member; a two-entry run queue parts the two.
// Reset: synchronous, active low; clears the open run, the queue and the output.
// Depends on tra_pkg, tra_front, tra_queue, tra_back.
module tied_run_averager_core #(
  parameter int MAX_RUN = tra_pkg::MAX_RUN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tra_pkg::VALUE_W-1:0] in_tdata,  // value
  input  logic                        in_tuser,  // tied_with_next
  input  logic                        in_tlast,  // final_element
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tra_pkg::VALUE_W-1:0] out_tdata, // mean_value
  output logic                        out_tlast, // last
  output logic                        out_tuser  // long_run
);
  import tra_pkg::*;

  localparam int SUM_W = VALUE_W + $clog2(MAX_RUN);
  localparam int CNT_W = $clog2(MAX_RUN + 1);
  localparam int REC_W = SUM_W + CNT_W + 1;

  logic             push, q_full, q_valid, pop;
  logic [REC_W-1:0] push_data, q_data;

  tra_front #(.MAX_RUN(MAX_RUN)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .push(push), .push_data(push_data), .q_full(q_full)
  );

  tra_queue #(.MAX_RUN(MAX_RUN)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(push_data), .q_full(q_full),
    .q_valid(q_valid), .q_data(q_data), .pop(pop)
  );

  tra_back #(.MAX_RUN(MAX_RUN)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_data(q_data), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );
endmodule
